// File: src/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared widths, limits and the report-candidate type of the string extractor.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int BUFFER_BYTES = 4096;

    localparam int ADDR_W = 48;
    localparam int NLEN_W = 13;
    localparam int WLEN_W = 12;

    localparam int NARROW_CAP_I = (BUFFER_BYTES < 8191) ? BUFFER_BYTES : 8191;
    localparam int WIDE_CAP_I   = ((BUFFER_BYTES / 2) < 4095) ? (BUFFER_BYTES / 2) : 4095;
    localparam logic [NLEN_W-1:0] NARROW_CAP = NLEN_W'(NARROW_CAP_I);
    localparam logic [WLEN_W-1:0] WIDE_CAP   = WLEN_W'(WIDE_CAP_I);

    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd127;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              nv;
        logic [ADDR_W-1:0] naddr;
        logic [NLEN_W-1:0] nlen;
        logic              wv;
        logic [ADDR_W-1:0] waddr;
        logic [WLEN_W-1:0] wlen;
    } t_entry;

    function automatic logic is_printable(input logic [7:0] b);
        return (b >= PRINT_LO) && (b < PRINT_HI);
    endfunction

endpackage

// File: src/pse_front.sv
// ----------------------------------------------------------------------------
// pse_front
// Run detectors: tracks narrow and UTF-16LE runs and raises report candidates.
// ----------------------------------------------------------------------------
module pse_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [7:0]                 i_data_byte,
    input  logic [pse_pkg::ADDR_W-1:0] i_byte_address,
    input  logic                       i_end_of_buffer,
    input  logic [7:0]                 i_min_length,
    output logic                       o_push,
    output pse_pkg::t_entry            o_entry
);

    localparam logic [1:0] PH_SEARCH     = 2'd0;
    localparam logic [1:0] PH_EXPECT_LOW = 2'd1;
    localparam logic [1:0] PH_HOLD_LOW   = 2'd2;

    logic [pse_pkg::NLEN_W-1:0] r_nlen,   n_nlen;
    logic [pse_pkg::ADDR_W-1:0] r_nstart, n_nstart;
    logic [1:0]                 r_phase,  n_phase;
    logic [pse_pkg::WLEN_W-1:0] r_wlen,   n_wlen;
    logic [pse_pkg::ADDR_W-1:0] r_wstart, n_wstart;
    logic [7:0]                 r_prev,   n_prev;
    logic                       r_pvalid, n_pvalid;
    logic [pse_pkg::ADDR_W-1:0] r_paddr,  n_paddr;

    logic [7:0] minl;
    logic       cur_p;
    logic       prev_p;
    logic       cur_zero;

    logic                       nrep_v;
    logic [pse_pkg::ADDR_W-1:0] nrep_addr;
    logic [pse_pkg::NLEN_W-1:0] nrep_len;
    logic                       wrep_v;
    logic [pse_pkg::ADDR_W-1:0] wrep_addr;
    logic [pse_pkg::WLEN_W-1:0] wrep_len;

    assign minl     = (i_min_length == 8'd0) ? 8'd1 : i_min_length;
    assign cur_p    = pse_pkg::is_printable(i_data_byte);
    assign prev_p   = pse_pkg::is_printable(r_prev);
    assign cur_zero = (i_data_byte == 8'd0);

    always_comb begin
        n_nlen    = r_nlen;
        n_nstart  = r_nstart;
        nrep_v    = 1'b0;
        nrep_addr = r_nstart;
        nrep_len  = r_nlen;
        if (cur_p) begin
            if (r_nlen == '0) begin
                n_nstart = i_byte_address;
            end
            if (r_nlen < pse_pkg::NARROW_CAP) begin
                n_nlen = r_nlen + 1'b1;
            end
            if (i_end_of_buffer) begin
                nrep_v    = (n_nlen >= {5'd0, minl});
                nrep_addr = n_nstart;
                nrep_len  = n_nlen;
                n_nlen    = '0;
            end
        end else begin
            nrep_v = (r_nlen >= {5'd0, minl});
            n_nlen = '0;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_wlen    = r_wlen;
        n_wstart  = r_wstart;
        n_prev    = r_prev;
        n_pvalid  = r_pvalid;
        n_paddr   = r_paddr;
        wrep_v    = 1'b0;
        wrep_addr = r_wstart;
        wrep_len  = r_wlen;
        unique case (r_phase)
            PH_EXPECT_LOW: begin
                n_prev   = i_data_byte;
                n_paddr  = i_byte_address;
                n_pvalid = 1'b1;
                n_phase  = PH_HOLD_LOW;
            end
            PH_HOLD_LOW: begin
                if (prev_p && cur_zero) begin
                    if (r_wlen < pse_pkg::WIDE_CAP) begin
                        n_wlen = r_wlen + 1'b1;
                    end
                    n_pvalid = 1'b0;
                    n_phase  = PH_EXPECT_LOW;
                end else begin
                    wrep_v   = (r_wlen >= {4'd0, minl});
                    n_wlen   = '0;
                    n_prev   = i_data_byte;
                    n_paddr  = i_byte_address;
                    n_pvalid = 1'b1;
                    n_phase  = PH_SEARCH;
                end
            end
            default: begin
                if (r_pvalid && prev_p && cur_zero) begin
                    n_wstart = r_paddr;
                    n_wlen   = {{(pse_pkg::WLEN_W-1){1'b0}}, 1'b1};
                    n_pvalid = 1'b0;
                    n_phase  = PH_EXPECT_LOW;
                end else begin
                    n_prev   = i_data_byte;
                    n_paddr  = i_byte_address;
                    n_pvalid = 1'b1;
                    n_phase  = PH_SEARCH;
                end
            end
        endcase
        if (i_end_of_buffer) begin
            if (n_phase != PH_SEARCH && n_wlen >= {4'd0, minl}) begin
                wrep_v    = 1'b1;
                wrep_addr = n_wstart;
                wrep_len  = n_wlen;
            end
            n_phase  = PH_SEARCH;
            n_wlen   = '0;
            n_pvalid = 1'b0;
            n_prev   = 8'd0;
        end
    end

    assign o_entry = '{nv: nrep_v, naddr: nrep_addr, nlen: nrep_len,
                       wv: wrep_v, waddr: wrep_addr, wlen: wrep_len};
    assign o_push  = i_accept && (nrep_v || wrep_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nlen   <= '0;
            r_nstart <= '0;
            r_phase  <= PH_SEARCH;
            r_wlen   <= '0;
            r_wstart <= '0;
            r_prev   <= 8'd0;
            r_pvalid <= 1'b0;
            r_paddr  <= '0;
        end else if (i_accept) begin
            r_nlen   <= n_nlen;
            r_nstart <= n_nstart;
            r_phase  <= n_phase;
            r_wlen   <= n_wlen;
            r_wstart <= n_wstart;
            r_prev   <= n_prev;
            r_pvalid <= n_pvalid;
            r_paddr  <= n_paddr;
        end
    end

endmodule

// File: src/pse_fifo.sv
// ----------------------------------------------------------------------------
// pse_fifo
// Short queue of report candidates between the detectors and the reporter.
// ----------------------------------------------------------------------------
module pse_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pse_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_head_valid,
    output pse_pkg::t_entry o_head
);

    pse_pkg::t_entry r_mem [pse_pkg::QUEUE_DEPTH];

    logic [pse_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [pse_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [pse_pkg::QCNT_W-1:0] r_count,  n_count;
    logic                       do_pop;

    assign o_full       = (r_count == pse_pkg::QCNT_W'(pse_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == pse_pkg::QPTR_W'(pse_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == pse_pkg::QPTR_W'(pse_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: src/pse_back.sv
// ----------------------------------------------------------------------------
// pse_back
// Reporter: applies the report budget and drives the result register.
// ----------------------------------------------------------------------------
module pse_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_head_valid,
    input  pse_pkg::t_entry            i_head,
    input  logic [15:0]                i_max_strings,
    input  logic                       i_ready,
    output logic                       o_pop,
    output logic                       o_valid,
    output logic [pse_pkg::ADDR_W-1:0] o_string_address,
    output logic [pse_pkg::NLEN_W-1:0] o_string_length,
    output logic                       o_is_wide,
    output logic                       o_last_result
);

    logic                       r_out_valid;
    logic [pse_pkg::ADDR_W-1:0] r_out_addr,  n_out_addr;
    logic [pse_pkg::NLEN_W-1:0] r_out_len,   n_out_len;
    logic                       r_out_wide,  n_out_wide;
    logic                       r_out_last,  n_out_last;
    logic                       r_sub,       n_sub;
    logic [15:0]                r_reported;
    logic                       n_load;
    logic                       slot_free;
    logic                       budget_ok;
    logic                       budget_ok2;
    logic [16:0]                reported_inc;

    assign slot_free    = !r_out_valid || i_ready;
    assign budget_ok    = (r_reported < i_max_strings);
    assign reported_inc = {1'b0, r_reported} + 17'd1;
    assign budget_ok2   = (reported_inc < {1'b0, i_max_strings});

    always_comb begin
        n_load     = 1'b0;
        o_pop      = 1'b0;
        n_sub      = r_sub;
        n_out_addr = i_head.waddr;
        n_out_len  = {1'b0, i_head.wlen};
        n_out_wide = 1'b1;
        n_out_last = 1'b1;
        if (i_head_valid && slot_free) begin
            if (r_sub) begin
                n_load = 1'b1;
                o_pop  = 1'b1;
                n_sub  = 1'b0;
            end else if (i_head.nv && budget_ok) begin
                n_load     = 1'b1;
                n_out_addr = i_head.naddr;
                n_out_len  = i_head.nlen;
                n_out_wide = 1'b0;
                if (i_head.wv && budget_ok2) begin
                    n_out_last = 1'b0;
                    n_sub      = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                o_pop  = 1'b1;
                n_load = i_head.wv && budget_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out_addr <= n_out_addr;
            r_out_len  <= n_out_len;
            r_out_wide <= n_out_wide;
            r_out_last <= n_out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sub       <= 1'b0;
            r_reported  <= '0;
        end else begin
            r_sub <= n_sub;
            if (n_load) begin
                r_out_valid <= 1'b1;
                r_reported  <= reported_inc[15:0];
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_string_address = r_out_addr;
    assign o_string_length  = r_out_len;
    assign o_is_wide        = r_out_wide;
    assign o_last_result    = r_out_last;

    a_sub_holds_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (r_out_valid && !r_out_wide && !r_out_last))
        else $error("pending wide report without a narrow one ahead");

    a_sub_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> i_head_valid)
        else $error("pending wide report with empty queue");

    a_count_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_load |=> (r_reported == $past(r_reported) + 16'd1))
        else $error("report count out of step");

    a_no_report_over_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_load |-> budget_ok)
        else $error("report beyond budget");

endmodule

// File: src/printable_string_extractor_top.sv
// ----------------------------------------------------------------------------
// printable_string_extractor_top
// Finds printable narrow and UTF-16LE runs in a byte stream and reports them.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while o_ready is high; each report is one o_valid/i_ready transfer.
// A byte's first report passes through the candidate queue and then the result register.
// A byte raising two reports holds one queue entry until both have been issued.
// o_ready drops only while the four-entry candidate queue is full.
// Reset: synchronous, active low; clears detectors, queue, budget count and
// restores min_length to 4 and max_strings to 65535. No clearing pass.
// ----------------------------------------------------------------------------
module printable_string_extractor_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_data_byte,
    input  logic [pse_pkg::ADDR_W-1:0] i_byte_address,
    input  logic                       i_end_of_buffer,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [pse_pkg::ADDR_W-1:0] o_string_address,
    output logic [pse_pkg::NLEN_W-1:0] o_string_length,
    output logic                       o_is_wide,
    output logic                       o_last_result
);

    localparam logic REG_MIN_LENGTH  = 1'b0;
    localparam logic REG_MAX_STRINGS = 1'b1;

    logic [7:0]      r_min_length;
    logic [15:0]     r_max_strings;
    logic            cfg_wr;
    logic            accept;
    logic            push;
    logic            pop;
    logic            full;
    logic            head_valid;
    pse_pkg::t_entry entry;
    pse_pkg::t_entry head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length  <= 8'd4;
            r_max_strings <= 16'hFFFF;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MIN_LENGTH:  r_min_length  <= pwdata[7:0];
                REG_MAX_STRINGS: r_max_strings <= pwdata[15:0];
                default:         r_min_length  <= r_min_length;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MIN_LENGTH:  prdata = {24'd0, r_min_length};
            REG_MAX_STRINGS: prdata = {16'd0, r_max_strings};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_ready = !full;
    assign accept  = i_valid && o_ready;

    pse_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_byte_address  (i_byte_address),
        .i_end_of_buffer (i_end_of_buffer),
        .i_min_length    (r_min_length),
        .o_push          (push),
        .o_entry         (entry)
    );

    pse_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (entry),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    pse_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (head_valid),
        .i_head           (head),
        .i_max_strings    (r_max_strings),
        .i_ready          (i_ready),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .o_string_address (o_string_address),
        .o_string_length  (o_string_length),
        .o_is_wide        (o_is_wide),
        .o_last_result    (o_last_result)
    );

endmodule
